>>> rtl/mcv_pkg.sv
// Package: manifest layout constants, result type and byte-wide CRC-32 update.
`timescale 1ns / 1ps

package mcv_pkg;

    localparam int CountWidth = 10;

    localparam logic [CountWidth-1:0] NAME_OFFSET       = 10'd8;
    localparam logic [CountWidth-1:0] NAME_FIELD_SIZE   = 10'd256;
    localparam logic [CountWidth-1:0] CHECKSUM_POSITION = 10'd840;

    localparam logic [CountWidth-1:0] NAME_END   = NAME_OFFSET + NAME_FIELD_SIZE;
    localparam logic [CountWidth-1:0] LAST_BYTE  = CHECKSUM_POSITION + 10'd3;
    localparam logic [CountWidth-1:0] COUNT_MAX  = 10'd1023;

    localparam logic [31:0] CRC_POLY     = 32'hedb88320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hffffffff;

    localparam logic [15:0] PAYLOAD_LENGTH = 16'd844;
    localparam logic [7:0]  VERSION_BYTE   = 8'd1;
    localparam logic [7:0]  ZERO_BYTE      = 8'd0;

    // Signature bytes 0..3, ASCII
    localparam logic [7:0] SIGNATURE [4] = '{8'h51, 8'h54, 8'h42, 8'h4d};

    typedef struct packed {
        logic       patched;
        logic       valid;
        logic       name_available;
        logic [7:0] name_length;
    } mcv_result_t;

    typedef struct packed {
        logic        fire;
        mcv_result_t result;
    } mcv_push_t;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/mcv_core.sv
// Manifest tracking core: per-word header, CRC, checksum and name scan state.
`timescale 1ns / 1ps

module mcv_core
    import mcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    output mcv_push_t  push
);

    logic [31:0]           crc_reg, crc_next, crc_cur;
    logic [CountWidth-1:0] count_reg, count_next, count_cur;
    logic                  magic_ok_reg, magic_ok_next, magic_ok_cur;
    logic                  header_ok_reg, header_ok_next, header_ok_cur;
    logic [31:0]           checksum_reg, checksum_next, checksum_cur;
    logic [7:0]            nul_pos_reg, nul_pos_next, nul_pos_cur;
    logic                  nul_seen_reg, nul_seen_next, nul_seen_cur;
    logic                  finished_reg, finished_next, finished_cur;
    logic [CountWidth-1:0] name_idx;
    logic [1:0]            lane;
    logic                  is_last;
    logic                  valid_flag;
    logic                  avail_flag;

    always_comb
    begin
        // first mark clears progress before this word is taken
        crc_cur       = first_byte ? CRC_ALL_ONES : crc_reg;
        count_cur     = first_byte ? '0 : count_reg;
        magic_ok_cur  = first_byte ? 1'b1 : magic_ok_reg;
        header_ok_cur = first_byte ? 1'b1 : header_ok_reg;
        checksum_cur  = first_byte ? '0 : checksum_reg;
        nul_pos_cur   = first_byte ? '0 : nul_pos_reg;
        nul_seen_cur  = first_byte ? 1'b0 : nul_seen_reg;
        finished_cur  = first_byte ? 1'b0 : finished_reg;

        crc_next       = crc_cur;
        count_next     = count_cur;
        magic_ok_next  = magic_ok_cur;
        header_ok_next = header_ok_cur;
        checksum_next  = checksum_cur;
        nul_pos_next   = nul_pos_cur;
        nul_seen_next  = nul_seen_cur;
        finished_next  = finished_cur;

        name_idx = count_cur - NAME_OFFSET;
        lane     = 2'(count_cur - CHECKSUM_POSITION);
        is_last  = (count_cur == LAST_BYTE);

        if (!finished_cur)
        begin
            if (count_cur < 10'd4)
            begin
                if (data_byte != SIGNATURE[count_cur[1:0]])
                    magic_ok_next = 1'b0;
            end
            else if (count_cur == 10'd4)
            begin
                if (data_byte != VERSION_BYTE) header_ok_next = 1'b0;
            end
            else if (count_cur == 10'd5)
            begin
                if (data_byte != ZERO_BYTE) header_ok_next = 1'b0;
            end
            else if (count_cur == 10'd6)
            begin
                if (data_byte != PAYLOAD_LENGTH[7:0]) header_ok_next = 1'b0;
            end
            else if (count_cur == 10'd7)
            begin
                if (data_byte != PAYLOAD_LENGTH[15:8]) header_ok_next = 1'b0;
            end

            if (count_cur < CHECKSUM_POSITION)
                crc_next = crc_byte(crc_cur, data_byte);
            else if (count_cur <= LAST_BYTE)
            begin
                for (int n = 0; n < 4; n++)
                begin
                    if (lane == 2'(n))
                        checksum_next[8*n +: 8] = checksum_cur[8*n +: 8] | data_byte;
                end
            end

            if (count_cur >= NAME_OFFSET && count_cur < NAME_END &&
                !nul_seen_cur && data_byte == 8'd0)
            begin
                nul_seen_next = 1'b1;
                nul_pos_next  = name_idx[7:0];
            end

            if (count_cur < COUNT_MAX)
                count_next = count_cur + 10'd1;

            if (is_last)
                finished_next = 1'b1;
        end

        valid_flag = magic_ok_next && header_ok_next &&
                     (checksum_next == (crc_next ^ CRC_ALL_ONES));
        avail_flag = valid_flag && nul_seen_next && (nul_pos_next != 8'd0);

        push.fire                  = accept && !finished_cur && is_last;
        push.result.patched        = magic_ok_next;
        push.result.valid          = valid_flag;
        push.result.name_available = avail_flag;
        push.result.name_length    = avail_flag ? nul_pos_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_ALL_ONES;
            count_reg     <= '0;
            magic_ok_reg  <= 1'b1;
            header_ok_reg <= 1'b1;
            checksum_reg  <= '0;
            nul_pos_reg   <= '0;
            nul_seen_reg  <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else if (accept)
        begin
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            magic_ok_reg  <= magic_ok_next;
            header_ok_reg <= header_ok_next;
            checksum_reg  <= checksum_next;
            nul_pos_reg   <= nul_pos_next;
            nul_seen_reg  <= nul_seen_next;
            finished_reg  <= finished_next;
        end
    end

    a_fire_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        push.fire |=> finished_reg)
        else $error("result given without marking manifest finished");

    a_finished_count: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (count_reg == LAST_BYTE + 10'd1))
        else $error("finished flag out of step with byte count");

    a_magic_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        !magic_ok_reg |-> (count_reg != '0))
        else $error("signature mismatch recorded before any word");

endmodule

>>> rtl/mcv_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
`timescale 1ns / 1ps

module mcv_out_buf
    import mcv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mcv_push_t   push,
    input  logic        out_stall,
    output logic        full,
    output logic        out_valid,
    output mcv_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    mcv_result_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    mcv_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push.fire)
            begin
                out_data_next  = push.result;
                out_valid_next = 1'b1;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (push.fire)
        begin
            skid_data_next  = push.result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push.fire)
        else $error("result pushed into full buffer");

    a_name_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.name_available) |-> out_data_reg.valid)
        else $error("name flagged on an invalid manifest");

endmodule

>>> rtl/manifest_crc_validator_top.sv
// Top level of the manifest CRC validator.
`timescale 1ns / 1ps

// Takes one manifest byte per word on the byte channel, one word per cycle
// while byte_stall is low, restarting whenever first_byte is set (a byte
// stream without a first mark after reset starts at byte 0). Signature,
// version, zero byte, payload length and a reflected CRC-32 over bytes 0..839
// are checked as the bytes go by, and the 256-byte name field at offset 8 is
// scanned for its first NUL. The word carrying byte 843 yields one result
// word; later bytes are dropped until the next first mark. The byte-wide CRC
// and header logic sits in front of the state registers. Results sit in a
// two-entry output buffer; byte_stall rises only when both entries are held,
// so a waiting result does not block input.

module manifest_crc_validator_top
    import mcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       manifest_patched,
    output logic       manifest_valid,
    output logic       name_available,
    output logic [7:0] name_length
);

    logic        accept;
    logic        buf_full;
    mcv_push_t   push;
    mcv_result_t result;

    assign byte_stall = buf_full;
    assign accept     = byte_valid && !buf_full;

    mcv_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .push       (push)
    );

    mcv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_stall (result_stall),
        .full      (buf_full),
        .out_valid (result_valid),
        .out_data  (result)
    );

    assign manifest_patched = result.patched;
    assign manifest_valid   = result.valid;
    assign name_available   = result.name_available;
    assign name_length      = result.name_length;

endmodule
